### rtl/core/s2lab_pkg.sv
// Shared constants, tables and elaboration-time functions for the sRGB to CIELAB pipeline.
`default_nettype none
package s2lab_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int CR_BITS_DEF   = 10;

   localparam int CH_W       = 8;
   localparam int IN_DATA_W  = 24;
   localparam int L_W        = 15;
   localparam int AB_W       = 16;
   localparam int OUT_DATA_W = 48;

   localparam int LIN_W  = 17;   // Q16 linear channel, 0 to 65536
   localparam int COEF_W = 17;
   localparam int SUM_W  = 33;   // scaled matrix sum plus rounding bias
   localparam int RCP_W  = 21;
   localparam int DIV_W  = 17;
   localparam int DIV_K  = 34;
   localparam int T_W    = 17;   // Q16 white-relative ratio
   localparam int F_W    = 17;   // Q16 f(t)
   localparam int LAB_W  = 28;   // Q16 L, a, b before rounding

   // linear branch of f: (7787*116*t + 2^20*1000 + 58000) / 116000
   localparam int LF_THR   = 581;
   localparam int LF_T_W   = 10;
   localparam int LF_NUM_W = 31;
   localparam int LF_RCP_W = 16;
   localparam int LF_K     = 32;
   localparam longint unsigned LF_MUL  = 64'd903292;
   localparam longint unsigned LF_BIAS = 64'd1048634000;
   localparam longint unsigned LF_DIV  = 64'd116000;
   localparam longint unsigned LF_RCP  = (64'd1 << LF_K) / LF_DIV;

   localparam int L_MUL = 116;
   localparam int L_OFS = 1048576;
   localparam int A_MUL = 500;
   localparam int B_MUL = 200;

   // X and Z rows carry the extra factor of ten of their divisors
   localparam logic [COEF_W-1:0] XYZ_COEF [0:2][0:2] = '{
      '{17'd41240, 17'd35760, 17'd18050},
      '{17'd2126,  17'd7152,  17'd722},
      '{17'd1930,  17'd11920, 17'd95050}
   };
   localparam logic [SUM_W-1:0] XYZ_BIAS [0:2] = '{33'd47523, 33'd5000, 33'd54441};
   localparam logic [DIV_W-1:0] XYZ_DIV  [0:2] = '{17'd95047, 17'd10000, 17'd108883};
   localparam logic [RCP_W-1:0] XYZ_RCP  [0:2] = '{
      RCP_W'((64'd1 << DIV_K) / 64'd95047),
      RCP_W'((64'd1 << DIV_K) / 64'd10000),
      RCP_W'((64'd1 << DIV_K) / 64'd108883)
   };

   typedef logic [LIN_W-1:0] lin_tbl_type [0:255];

   // sRGB inverse gamma in Q16, bit-exact integer form
   function automatic longint unsigned lin_q16(input longint unsigned c);
      longint unsigned u30, s, lo, hi, mid, p;
      if (c <= 64'd10)
         return (c * 64'd6553600 + 64'd164730) / 64'd329460;
      u30 = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
      s   = (u30 * u30) >> 30;
      lo  = 64'd0;
      hi  = 64'd1 << 30;
      for (int i = 0; i < 32; i++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            p   = mid;
            for (int j = 0; j < 4; j++)
               p = (p * mid) >> 30;
            if (p <= s)
               lo = mid;
            else
               hi = mid - 64'd1;
         end
      end
      return (((s * lo) >> 30) + 64'd8192) >> 14;
   endfunction

   function automatic lin_tbl_type lin_tbl_build();
      lin_tbl_type tbl;
      for (int c = 0; c < 256; c++)
         tbl[c] = LIN_W'(lin_q16(64'(c)));
      return tbl;
   endfunction

   // floor(cbrt(x * 2^32)) at the table point idx
   function automatic longint unsigned cube_pt(input longint unsigned idx, input int shift);
      longint unsigned x, lo, hi, mid;
      x  = (idx << shift) << 32;
      lo = 64'd0;
      hi = 64'd1 << 17;
      for (int i = 0; i < 20; i++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (mid * mid * mid <= x)
               lo = mid;
            else
               hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

endpackage
`default_nettype wire

### rtl/core/s2lab_lin.sv
// Stage 0: per-channel sRGB linearization through a 256-entry constant table.
`default_nettype none
module s2lab_lin import s2lab_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [2:0][CH_W-1:0]       chan,
   output logic      [2:0][LIN_W-1:0]      lin_ff
);

   localparam lin_tbl_type LIN_TBL = lin_tbl_build();

   logic [2:0][LIN_W-1:0] lin_in;

   always_comb begin
      for (int k = 0; k < 3; k++)
         lin_in[k] = LIN_TBL[chan[k]];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff <= lin_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/s2lab_xyz.sv
// Stages 1-3: RGB to XYZ matrix and division by the D65 white via reciprocal multiply.
`default_nettype none
module s2lab_xyz import s2lab_pkg::*; (
   input  wire logic                       clock,
   input  wire logic [2:0]                 en,
   input  wire logic [2:0][LIN_W-1:0]      lin,
   output logic      [2:0][T_W-1:0]        t_ff
);

   localparam int P_W = SUM_W + RCP_W;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [SUM_W-1:0] term0, term1, term2, sum_in, sum_ff;
      logic [P_W-1:0]   prod;
      logic [T_W-1:0]   q0_in, q0_ff, t_in;
      logic [SUM_W-1:0] num_ff, qd, rem;

      // stage 1: weighted sum plus rounding bias
      always_comb begin
         term0  = SUM_W'(XYZ_COEF[k][0]) * SUM_W'(lin[0]);
         term1  = SUM_W'(XYZ_COEF[k][1]) * SUM_W'(lin[1]);
         term2  = SUM_W'(XYZ_COEF[k][2]) * SUM_W'(lin[2]);
         sum_in = term0 + term1 + term2 + XYZ_BIAS[k];
      end

      // stage 2: quotient estimate, low by at most one
      always_comb begin
         prod  = P_W'(sum_ff) * P_W'(XYZ_RCP[k]);
         q0_in = prod[DIV_K +: T_W];
      end

      // stage 3: one correction step
      always_comb begin
         qd   = SUM_W'(q0_ff) * SUM_W'(XYZ_DIV[k]);
         rem  = num_ff - qd;
         t_in = q0_ff + T_W'(rem >= SUM_W'(XYZ_DIV[k]));
      end

      always_ff @(posedge clock) begin
         if (en[0]) begin
            sum_ff <= sum_in;
         end
         if (en[1]) begin
            num_ff <= sum_ff;
            q0_ff  <= q0_in;
         end
         if (en[2]) begin
            t_ff[k] <= t_in;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/s2lab_f.sv
// Stages 4-6: CIELAB f(t), interpolated cube root above the knee, linear segment below.
`default_nettype none
module s2lab_f import s2lab_pkg::*; #(
   parameter int CR_BITS = CR_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic [2:0]           en,
   input  wire logic [T_W-1:0]       t,
   output logic      [F_W-1:0]       f_ff
);

   localparam int CR_SHIFT = T_W - CR_BITS;
   localparam int N_PT     = 1 << CR_BITS;
   localparam int D_W      = F_W + CR_SHIFT;
   localparam int LP_W     = LF_NUM_W + LF_RCP_W;
   localparam logic [D_W-1:0] HALF = D_W'(1) << (CR_SHIFT - 1);

   logic [F_W-1:0] rom [0:N_PT];

   for (genvar k = 0; k <= N_PT; k++) begin : g_rom
      assign rom[k] = F_W'(cube_pt(64'(k), CR_SHIFT));
   end

   logic [CR_BITS:0]    idx0, idx1;
   logic [F_W-1:0]      e0_in, e1_in, e0_ff, e1_ff, e0b_ff;
   logic [CR_SHIFT-1:0] fr_ff;
   logic [LF_NUM_W-1:0] num_in, num_ff, numb_ff, qd, rem;
   logic                sel_ff, selb_ff;
   logic [F_W-1:0]      diff, q0_in, q0_ff, cube, lseg, f_in;
   logic [D_W-1:0]      d_in, d_ff;
   logic [LP_W-1:0]     prod;

   // stage A: table fetch and linear-segment numerator
   always_comb begin
      idx0   = {1'b0, t[T_W-1:CR_SHIFT]};
      idx1   = idx0 + 1'b1;
      e0_in  = rom[idx0];
      e1_in  = rom[idx1];
      num_in = LF_NUM_W'(LF_MUL) * LF_NUM_W'(t[LF_T_W-1:0]) + LF_NUM_W'(LF_BIAS);
   end

   // stage B: interpolation product and reciprocal product
   always_comb begin
      diff  = e1_ff - e0_ff;
      d_in  = D_W'(diff) * D_W'(fr_ff);
      prod  = LP_W'(num_ff) * LP_W'(LF_RCP);
      q0_in = prod[LF_K +: F_W];
   end

   // stage C: finish both branches and pick one
   always_comb begin
      cube = e0b_ff + F_W'((d_ff + HALF) >> CR_SHIFT);
      qd   = LF_NUM_W'(q0_ff) * LF_NUM_W'(LF_DIV);
      rem  = numb_ff - qd;
      lseg = q0_ff + F_W'(rem >= LF_NUM_W'(LF_DIV));
      f_in = selb_ff ? lseg : cube;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e0_ff  <= e0_in;
         e1_ff  <= e1_in;
         fr_ff  <= t[CR_SHIFT-1:0];
         num_ff <= num_in;
         sel_ff <= t < T_W'(LF_THR);
      end
      if (en[1]) begin
         e0b_ff  <= e0_ff;
         d_ff    <= d_in;
         q0_ff   <= q0_in;
         numb_ff <= num_ff;
         selb_ff <= sel_ff;
      end
      if (en[2]) begin
         f_ff <= f_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/s2lab_out.sv
// Stages 7-8: L, a, b in Q16, then rounding to the output format and saturation.
`default_nettype none
module s2lab_out import s2lab_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic [1:0]           en,
   input  wire logic [F_W-1:0]       fx,
   input  wire logic [F_W-1:0]       fy,
   input  wire logic [F_W-1:0]       fz,
   output logic      [L_W-1:0]       lightness_ff,
   output logic      [AB_W-1:0]      green_red_ff,
   output logic      [AB_W-1:0]      blue_yellow_ff
);

   localparam int RS   = 16 - FRAC_BITS;
   localparam int LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
   localparam logic [LAB_W-1:0]        HALF   = LAB_W'(1) << (RS - 1);
   localparam logic signed [LAB_W-1:0] L_MAXS = LAB_W'(LMAX);
   localparam logic signed [LAB_W-1:0] AB_MIN = LAB_W'(-32768);
   localparam logic signed [LAB_W-1:0] AB_MAX = LAB_W'(32767);

   function automatic logic signed [LAB_W-1:0] rnd(input logic signed [LAB_W-1:0] v);
      logic [LAB_W-1:0] m, r;
      m = v[LAB_W-1] ? -v : v;
      r = (m + HALF) >> RS;
      return v[LAB_W-1] ? $signed(-r) : $signed(r);
   endfunction

   logic signed [LAB_W-1:0] fxs, fys, fzs;
   logic signed [LAB_W-1:0] lv_in, av_in, bv_in, lv_ff, av_ff, bv_ff;
   logic signed [LAB_W-1:0] lr, ar, br;
   logic [L_W-1:0]          l_in;
   logic [AB_W-1:0]         a_in, b_in;

   always_comb begin
      fxs   = LAB_W'(fx);
      fys   = LAB_W'(fy);
      fzs   = LAB_W'(fz);
      lv_in = fys * LAB_W'(L_MUL) - LAB_W'(L_OFS);
      av_in = (fxs - fys) * LAB_W'(A_MUL);
      bv_in = (fys - fzs) * LAB_W'(B_MUL);
   end

   always_comb begin
      lr = rnd(lv_ff);
      ar = rnd(av_ff);
      br = rnd(bv_ff);
      if (lr[LAB_W-1])
         l_in = '0;
      else if (lr > L_MAXS)
         l_in = L_MAXS[L_W-1:0];
      else
         l_in = lr[L_W-1:0];
      if (ar < AB_MIN)
         a_in = AB_MIN[AB_W-1:0];
      else if (ar > AB_MAX)
         a_in = AB_MAX[AB_W-1:0];
      else
         a_in = ar[AB_W-1:0];
      if (br < AB_MIN)
         b_in = AB_MIN[AB_W-1:0];
      else if (br > AB_MAX)
         b_in = AB_MAX[AB_W-1:0];
      else
         b_in = br[AB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lv_ff <= lv_in;
         av_ff <= av_in;
         bv_ff <= bv_in;
      end
      if (en[1]) begin
         lightness_ff   <= l_in;
         green_red_ff   <= a_in;
         blue_yellow_ff <= b_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/srgb8_to_cielab.sv
// Top level: sRGB 8-bit pixel to CIELAB (D65), nine-stage pipeline.
//
//  channel | dir | tdata fields, low bit up
//  req     | in  | red[7:0] green[15:8] blue[23:16]
//  rsp     | out | lightness[14:0] green_red[30:15] blue_yellow[46:31], bit 47 zero
//
//  One item per cycle sustained while rsp is not stalled; an accepted req item reaches
//  rsp_tvalid after passing through stages 0 to 8 in order.
//  Depth is set by the two reciprocal divides (matrix, f linear segment), three stages each.
//  Every stage has its own valid bit and loads when it is empty or its successor moves,
//  so bubbles collapse and a stalled rsp side backs up without loss.
//  reset clears the valid bits only; no clearing pass.
`default_nettype none
module srgb8_to_cielab import s2lab_pkg::*; #(
   parameter int FRAC_BITS            = FRAC_BITS_DEF,
   parameter int CUBE_ROOT_TABLE_BITS = CR_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [IN_DATA_W-1:0]   req_tdata,   // red, green, blue
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [OUT_DATA_W-1:0]       rsp_tdata    // lightness, green_red, blue_yellow, pad
);

   localparam int N_STG = 9;

   logic [N_STG-1:0]         vld_ff, vld_in, en;
   logic [2:0][CH_W-1:0]     chan;
   logic [2:0][LIN_W-1:0]    lin;
   logic [2:0][T_W-1:0]      t;
   logic [2:0][F_W-1:0]      f;
   logic [L_W-1:0]           lightness;
   logic [AB_W-1:0]          green_red, blue_yellow;

   always_comb begin
      en[N_STG-1] = !vld_ff[N_STG-1] || rsp_tready;
      for (int i = N_STG - 2; i >= 0; i--)
         en[i] = !vld_ff[i] || en[i+1];
      vld_in = vld_ff;
      if (en[0])
         vld_in[0] = req_tvalid;
      for (int i = 1; i < N_STG; i++) begin
         if (en[i])
            vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[N_STG-1];
   assign chan[0]    = req_tdata[CH_W-1:0];
   assign chan[1]    = req_tdata[2*CH_W-1:CH_W];
   assign chan[2]    = req_tdata[3*CH_W-1:2*CH_W];

   s2lab_lin u_lin (
      .clock  (clock),
      .en     (en[0]),
      .chan   (chan),
      .lin_ff (lin)
   );

   s2lab_xyz u_xyz (
      .clock (clock),
      .en    (en[3:1]),
      .lin   (lin),
      .t_ff  (t)
   );

   for (genvar k = 0; k < 3; k++) begin : g_f
      s2lab_f #(
         .CR_BITS (CUBE_ROOT_TABLE_BITS)
      ) u_f (
         .clock (clock),
         .en    (en[6:4]),
         .t     (t[k]),
         .f_ff  (f[k])
      );
   end

   s2lab_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock          (clock),
      .en             (en[8:7]),
      .fx             (f[0]),
      .fy             (f[1]),
      .fz             (f[2]),
      .lightness_ff   (lightness),
      .green_red_ff   (green_red),
      .blue_yellow_ff (blue_yellow)
   );

   assign rsp_tdata = {(OUT_DATA_W - L_W - 2*AB_W)'(0), blue_yellow, green_red, lightness};

endmodule
`default_nettype wire

### rtl/core/s2lab_chk.sv
// Port-level checker for srgb8_to_cielab and its bind.
`default_nettype none
module s2lab_chk import s2lab_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [OUT_DATA_W-1:0] rsp_tdata
);

   localparam int LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // the pipe only refuses input when it is full and the output is blocked
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

   a_l_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[L_W-1:0] <= L_W'(LMAX))
      else $error("lightness above saturation limit");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result present right after reset");

endmodule

bind srgb8_to_cielab s2lab_chk #(
   .FRAC_BITS (FRAC_BITS)
) u_s2lab_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### verif/srgb8_to_cielab_checker.sv
// Checker for the sRGB to CIELAB block: predicts each pixel's Lab value and compares.
module srgb8_to_cielab_checker import s2lab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_DATA_W-1:0] rsp_tdata,
   output int                    error_count,
   output int                    pixel_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC    = FRAC_BITS_DEF;
   localparam int TBL_SH  = 17 - CR_BITS_DEF;

   typedef struct packed {
      logic [L_W-1:0]  lightness;
      logic [AB_W-1:0] green_red;
      logic [AB_W-1:0] blue_yellow;
   } lab_type;

   lab_type lab_queue[$];
   longint unsigned gamma_lut[256];
   longint unsigned cube_lut[(1 << CR_BITS_DEF) + 1];

   function automatic longint unsigned decode_gamma(longint unsigned c);
      longint unsigned u30, s, lo, hi, mid, p;
      if (c <= 10)
         return (c * 6553600 + 164730) / 329460;
      u30 = ((1000 * c + 14025) << 30) / 269025;
      s = (u30 * u30) >> 30;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         p = mid;
         repeat (4) p = (p * mid) >> 30;
         if (p <= s) lo = mid;
         else hi = mid - 1;
      end
      return (((s * lo) >> 30) + 8192) >> 14;
   endfunction

   function automatic longint unsigned cube_root(longint unsigned x);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 17;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (mid * mid * mid <= x) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint lab_f(longint unsigned t);
      longint unsigned idx, fr, e0, e1;
      if (t < LF_THR)
         return (7787 * 116 * t + 1048576000 + 58000) / 116000;
      if (t > (64'd1 << 17) - 1) t = (64'd1 << 17) - 1;
      idx = t >> TBL_SH;
      fr = t & ((64'd1 << TBL_SH) - 1);
      e0 = cube_lut[idx];
      e1 = cube_lut[idx + 1];
      return e0 + (((e1 - e0) * fr + (64'd1 << (TBL_SH - 1))) >> TBL_SH);
   endfunction

   function automatic longint round_frac(longint v);
      int sh;
      sh = 16 - FRAC;
      if (sh <= 0) return v;
      if (v >= 0) return (v + (64'sd1 << (sh - 1))) >>> sh;
      return -((-v + (64'sd1 << (sh - 1))) >>> sh);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic lab_type convert_pixel(logic [IN_DATA_W-1:0] px);
      longint unsigned r, g, b, tx, ty, tz;
      longint fx, fy, fz, lmax;
      lab_type res;
      r = gamma_lut[px[7:0]];
      g = gamma_lut[px[15:8]];
      b = gamma_lut[px[23:16]];
      tx = (10 * (4124 * r + 3576 * g + 1805 * b) + 47523) / 95047;
      ty = ((2126 * r + 7152 * g + 722 * b) + 5000) / 10000;
      tz = (10 * (193 * r + 1192 * g + 9505 * b) + 54441) / 108883;
      fx = lab_f(tx);
      fy = lab_f(ty);
      fz = lab_f(tz);
      lmax = 100 << FRAC;
      if (lmax > 32767) lmax = 32767;
      res.lightness = L_W'(clip(round_frac(116 * fy - 16 * 65536), 0, lmax));
      res.green_red = AB_W'(clip(round_frac(500 * (fx - fy)), -32768, 32767));
      res.blue_yellow = AB_W'(clip(round_frac(200 * (fy - fz)), -32768, 32767));
      return res;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pixel_count = 0;
      for (int c = 0; c < 256; c++) gamma_lut[c] = decode_gamma(c);
      for (int i = 0; i <= (1 << CR_BITS_DEF); i++)
         cube_lut[i] = cube_root((64'(i) << TBL_SH) << 32);
   end

   always @(posedge clock) begin
      lab_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            lab_queue.push_back(convert_pixel(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            pixel_count++;
            if (lab_queue.size() == 0) begin
               report("unexpected item", rsp_tdata, 0);
            end else begin
               want = lab_queue.pop_front();
               if (rsp_tdata[14:0] !== want.lightness)
                  report("lightness", rsp_tdata[14:0], want.lightness);
               if (rsp_tdata[30:15] !== want.green_red)
                  report("green_red", $signed(rsp_tdata[30:15]), $signed(want.green_red));
               if (rsp_tdata[46:31] !== want.blue_yellow)
                  report("blue_yellow", $signed(rsp_tdata[46:31]),
                         $signed(want.blue_yellow));
               if (rsp_tdata[47] !== 1'b0)
                  report("pad bit", rsp_tdata[47], 0);
            end
         end
      end
   end

   function automatic int pending();
      return lab_queue.size();
   endfunction
endmodule

### verif/srgb8_to_cielab_test.sv
// Testbench top: drives pixels with random gaps and back-pressure, gives the verdict.
module srgb8_to_cielab_test;
   import s2lab_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 1250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   int                    error_count, pixel_count;
   bit                    calm = 1'b0;
   logic [IN_DATA_W-1:0]  pixels[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   srgb8_to_cielab u_top (.*);

   srgb8_to_cielab_checker u_checker (.*);

   // rsp back-pressure in bursts, none once the run is calm
   always @(posedge clock) begin
      int hold;
      if (!reset && !calm && $urandom_range(0, 9) == 0) begin
         hold = $urandom_range(1, 14);
         rsp_tready <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   task automatic send_pixel(logic [IN_DATA_W-1:0] px);
      int gap;
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [7:0] r, g, b;
      int wait_cycles;
      // corners of the cube, greys, primaries, both sides of the gamma knee
      pixels = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                 24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h010101, 24'h0A0A0A,
                 24'h0B0B0B, 24'h808080, 24'h0A0B0A, 24'hFF0001, 24'h00FF01,
                 24'hAA55AA, 24'h55AA55, 24'h020000, 24'h000002, 24'h000200,
                 24'hFEFEFE, 24'h7F7F7F, 24'h0000FE};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (pixels[i]) send_pixel(pixels[i]);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i > RANDOM_PIXELS * 9 / 10) calm = 1'b1;
         r = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 12)) : 8'($urandom);
         g = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 12)) : 8'($urandom);
         b = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 12)) : 8'($urandom);
         send_pixel({b, g, r});
      end
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (u_checker.pending() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      $display("Converted %0d pixels: cube corners, gamma knee and random colors,",
               pixel_count);
      $display("with random gaps and back-pressure on both channels.");
      if (error_count == 0 && u_checker.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
